### rtl/assert_macros.svh
// Assertion macros used by the checker file of the settings image validator.
// Needs a clock named clk and an active-low reset named arst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/civ_pkg.sv
// Shared types, constants and the CRC-16 byte update for the settings image validator.
// No dependencies; every module of the block refers to this package by scoped names.
package civ_pkg;

	localparam int ADDR_BITS_DEF = 16;

	localparam logic [15:0] CRC_POLY        = 16'h1021;
	localparam logic [15:0] HDR_BYTES       = 16'd6;
	localparam logic [15:0] REGION_SIZE_RST = 16'hFFFF;
	localparam logic [7:0]  FORMAT_RST      = 8'h00;

	// Register indexes on the configuration port (paddr bit 2).
	localparam logic REG_FORMAT_VERSION = 1'b0;
	localparam logic REG_REGION_SIZE    = 1'b1;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// Verdict codes.
	localparam logic [2:0] ERR_OK       = 3'd0;
	localparam logic [2:0] ERR_FORMAT   = 3'd1;
	localparam logic [2:0] ERR_HDR_PAST = 3'd2;
	localparam logic [2:0] ERR_BAD_SIZE = 3'd3;
	localparam logic [2:0] ERR_CRC      = 3'd4;
	localparam logic [2:0] ERR_OVERRUN  = 3'd5;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_SIZE_LO = 3'd1,
		PH_SIZE_HI = 3'd2,
		PH_BODY    = 3'd3,
		PH_CHK_LO  = 3'd4,
		PH_CHK_HI  = 3'd5
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_image;
	} in_item_t;

	typedef struct packed {
		logic        image_ok;
		logic [2:0]  error_code;
		logic [15:0] image_size;
	} out_item_t;

	typedef struct packed {
		logic [7:0]  format_version;
		logic [15:0] region_size;
	} cfg_t;

	typedef struct packed {
		logic advance;
		logic fire;
	} scan_status_t;

	// CRC-16, polynomial 0x1021, MSB first, one byte.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

### rtl/civ_regs.sv
// Configuration registers of the settings image validator behind an APB-style port.
// Depends on civ_pkg for the register indexes, reset values and cfg_t.
module civ_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [civ_pkg::PADDR_W-1:0]   paddr,
	input  logic [civ_pkg::PDATA_W-1:0]   pwdata,
	output logic [civ_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output civ_pkg::cfg_t                 cfg
);

	civ_pkg::cfg_t cfg_q;
	logic          wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.format_version <= civ_pkg::FORMAT_RST;
			cfg_q.region_size    <= civ_pkg::REGION_SIZE_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				civ_pkg::REG_FORMAT_VERSION: cfg_q.format_version <= pwdata[7:0];
				civ_pkg::REG_REGION_SIZE:    cfg_q.region_size    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			civ_pkg::REG_FORMAT_VERSION: prdata = {24'h000000, cfg_q.format_version};
			civ_pkg::REG_REGION_SIZE:    prdata = {16'h0000, cfg_q.region_size};
			default:                     prdata = '0;
		endcase
	end

endmodule

### rtl/civ_scan.sv
// Scan FSM for settings images: CRC, bounds, one byte per cycle unless a verdict stalls.
// Depends on civ_pkg for the phase enum, verdict codes, item types and crc16_byte.
module civ_scan #(
	parameter int ADDR_BITS = civ_pkg::ADDR_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  civ_pkg::cfg_t          cfg,
	input  logic                   item_valid_s1,
	input  civ_pkg::in_item_t      item_s1,
	input  logic                   out_free,
	output civ_pkg::scan_status_t  status,
	output civ_pkg::out_item_t     res
);

	localparam int SUM_W = ((ADDR_BITS > 16) ? ADDR_BITS : 16) + 1;

	civ_pkg::phase_t        phase_q, phase_d;
	logic [ADDR_BITS-1:0]   offset_q, offset_d;
	logic [ADDR_BITS-1:0]   rstart_q, rstart_d;
	logic [15:0]            rem_q, rem_d;
	logic [7:0]             lo_q, lo_d;
	logic [15:0]            crc_q, crc_d;

	logic [ADDR_BITS-1:0]   off;
	logic [SUM_W-1:0]       off_x, off_inc, region_x, rs_hdr, rs_size;
	logic [15:0]            rec_size, rem_dec, crc_new;
	logic                   active, has_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= civ_pkg::PH_IDLE;
			offset_q <= '0;
			rstart_q <= '0;
			rem_q    <= '0;
			lo_q     <= '0;
			crc_q    <= '0;
		end else if (status.advance) begin
			phase_q  <= phase_d;
			offset_q <= offset_d;
			rstart_q <= rstart_d;
			rem_q    <= rem_d;
			lo_q     <= lo_d;
			crc_q    <= crc_d;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		offset_d = offset_q;
		rstart_d = rstart_q;
		rem_d    = rem_q;
		lo_d     = lo_q;
		crc_d    = crc_q;
		has_res  = 1'b0;
		res      = '0;

		off      = item_s1.start_of_image ? '0 : offset_q;
		off_x    = SUM_W'(off);
		off_inc  = off_x + SUM_W'(1);
		region_x = SUM_W'(cfg.region_size);
		rec_size = {item_s1.data_byte, lo_q};
		rs_hdr   = SUM_W'(rstart_q) + SUM_W'(civ_pkg::HDR_BYTES);
		rs_size  = SUM_W'(rstart_q) + SUM_W'(rec_size);
		crc_new  = civ_pkg::crc16_byte(crc_q, item_s1.data_byte);
		rem_dec  = (rem_q != 16'd0) ? (rem_q - 16'd1) : rem_q;
		active   = item_s1.start_of_image || (phase_q != civ_pkg::PH_IDLE);

		if (!active) begin
			phase_d = civ_pkg::PH_IDLE;
		end else if (off_x >= region_x) begin
			// Any byte at or past the end of the region ends the scan.
			has_res        = 1'b1;
			res.error_code = civ_pkg::ERR_OVERRUN;
			phase_d        = civ_pkg::PH_IDLE;
		end else begin
			offset_d = off_inc[ADDR_BITS-1:0];
			if (item_s1.start_of_image) begin
				if (item_s1.data_byte != cfg.format_version) begin
					has_res        = 1'b1;
					res.error_code = civ_pkg::ERR_FORMAT;
					phase_d        = civ_pkg::PH_IDLE;
				end else begin
					crc_d    = civ_pkg::crc16_byte(16'h0000, item_s1.data_byte);
					rstart_d = ADDR_BITS'(1);
					phase_d  = civ_pkg::PH_SIZE_LO;
				end
			end else begin
				unique case (phase_q)
					civ_pkg::PH_SIZE_LO: begin
						crc_d   = crc_new;
						lo_d    = item_s1.data_byte;
						phase_d = civ_pkg::PH_SIZE_HI;
					end
					civ_pkg::PH_SIZE_HI: begin
						crc_d = crc_new;
						if (rec_size == 16'd0) begin
							// A zero size is the terminator; the checksum follows.
							phase_d = civ_pkg::PH_CHK_LO;
						end else if (rs_hdr >= region_x) begin
							has_res        = 1'b1;
							res.error_code = civ_pkg::ERR_HDR_PAST;
							phase_d        = civ_pkg::PH_IDLE;
						end else if ((rec_size < civ_pkg::HDR_BYTES) || (rs_size >= region_x)) begin
							has_res        = 1'b1;
							res.error_code = civ_pkg::ERR_BAD_SIZE;
							phase_d        = civ_pkg::PH_IDLE;
						end else begin
							rem_d   = rec_size - 16'd2;
							phase_d = civ_pkg::PH_BODY;
						end
					end
					civ_pkg::PH_BODY: begin
						crc_d = crc_new;
						rem_d = rem_dec;
						if (rem_dec == 16'd0) begin
							rstart_d = off_inc[ADDR_BITS-1:0];
							phase_d  = civ_pkg::PH_SIZE_LO;
						end
					end
					civ_pkg::PH_CHK_LO: begin
						lo_d    = item_s1.data_byte;
						phase_d = civ_pkg::PH_CHK_HI;
					end
					civ_pkg::PH_CHK_HI: begin
						has_res        = 1'b1;
						res.image_ok   = (rec_size == crc_q);
						res.error_code = (rec_size == crc_q) ? civ_pkg::ERR_OK : civ_pkg::ERR_CRC;
						res.image_size = off_inc[15:0];
						phase_d        = civ_pkg::PH_IDLE;
					end
					default: begin
						phase_d = civ_pkg::PH_IDLE;
					end
				endcase
			end
		end
	end

	// A byte that gives no verdict moves on even while the result register is full.
	assign status.advance = item_valid_s1 && (!has_res || out_free);
	assign status.fire    = status.advance && has_res;

endmodule

### rtl/config_image_validator_core.sv
// Top level of the settings image validator: input register, scan logic, result register.
// Depends on civ_pkg, civ_regs and civ_scan.
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+--------------------------------------
//  item     | item_valid / item_stall       | item_data   (data_byte, start_of_image)
//  result   | result_valid / result_stall   | result_data (image_ok, error_code, image_size)
//  config   | psel penable pwrite pready    | paddr, pwdata, prdata
//
// One byte is taken per cycle unless a verdict stalls; the verdict goes to the result register.
// The byte is registered, then the scan state, the byte CRC and the bound compares settle it.
// Reset clears the handshake flags and returns the scan to idle.
// A stalled result holds; bytes that give no verdict keep flowing behind it.
module config_image_validator_core #(
	parameter int ADDR_BITS = civ_pkg::ADDR_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  civ_pkg::in_item_t             item_data,
	output logic                          result_valid,
	input  logic                          result_stall,
	output civ_pkg::out_item_t            result_data,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [civ_pkg::PADDR_W-1:0]   paddr,
	input  logic [civ_pkg::PDATA_W-1:0]   pwdata,
	output logic [civ_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	civ_pkg::cfg_t         cfg;
	civ_pkg::scan_status_t status;
	civ_pkg::out_item_t    res;
	civ_pkg::in_item_t     item_s1;
	civ_pkg::out_item_t    result_q;
	logic                  item_valid_s1;
	logic                  result_valid_q;
	logic                  out_free;

	civ_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	civ_scan #(
		.ADDR_BITS (ADDR_BITS)
	) u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.item_valid_s1 (item_valid_s1),
		.item_s1       (item_s1),
		.out_free      (out_free),
		.status        (status),
		.res           (res)
	);

	assign out_free   = !result_valid_q || !result_stall;
	assign item_stall = item_valid_s1 && !status.advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			item_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (status.fire) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (status.fire) begin
			result_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign result_data  = result_q;

endmodule

### rtl/civ_checker.sv
// Port-level checks on the result channel of the settings image validator, bound to the top.
// Depends on civ_pkg and assert_macros.svh.
`include "assert_macros.svh"

module civ_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               result_valid,
	input logic               result_stall,
	input civ_pkg::out_item_t result_data
);

	`ASSERT_CLK(a_stall_hold,
		result_valid && result_stall |=> result_valid && $stable(result_data),
		"stalled result changed")

	`ASSERT_CLK(a_ok_matches_code,
		result_valid |-> (result_data.image_ok == (result_data.error_code == civ_pkg::ERR_OK)),
		"image_ok disagrees with error_code")

	`ASSERT_CLK(a_code_range,
		result_valid |-> (result_data.error_code <= civ_pkg::ERR_OVERRUN),
		"error_code out of range")

	`ASSERT_CLK(a_size_on_error,
		result_valid && (result_data.error_code != civ_pkg::ERR_OK)
			&& (result_data.error_code != civ_pkg::ERR_CRC)
			|-> (result_data.image_size == 16'd0),
		"nonzero size on a structural error")

	// The asynchronous reset clears the flags without waiting for a clock edge.
	`ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !result_valid, "result valid during reset")

endmodule

bind config_image_validator_core civ_checker u_civ_checker (.*);
